// ----- hdl/lct_pkg.sv -----
// Package with shared constants, types and the neighbor offset table of the toggle block.
`default_nettype none
package lct_pkg;

  localparam int MAX_SIDE  = 64;
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int ADDR_W    = 2 * SIDE_W;
  localparam int CELLS     = MAX_SIDE * MAX_SIDE;
  localparam int CFG_W     = 7;
  localparam int CNT_W     = 4;
  localparam int STEP_W    = 4;
  localparam int COORD_W   = SIDE_W + 2;

  localparam logic [CFG_W-1:0]  SIDE_RESET = CFG_W'(MAX_SIDE);
  localparam logic [CFG_W-1:0]  SIDE_MAX   = CFG_W'(MAX_SIDE);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = CNT_W'(8);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_CTR   = STEP_W'(0);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_PUSH
  } lct_state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic run;
    logic load_out;
  } lct_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic bad;
    logic run_last;
    logic out_busy;
  } lct_status_t;

  typedef struct packed {
    logic             alive;
    logic [CNT_W-1:0] count;
  } lct_entry_t;

  typedef struct packed {
    logic signed [1:0] dr;
    logic signed [1:0] dc;
  } lct_off_t;

  // Step zero is the toggled cell itself; steps one to eight walk its neighbors.
  function automatic lct_off_t nb_offset(input logic [STEP_W-1:0] step);
    lct_off_t o;
    unique case (step)
      STEP_W'(1): o = '{dr: -2'sd1, dc: -2'sd1};
      STEP_W'(2): o = '{dr: -2'sd1, dc:  2'sd0};
      STEP_W'(3): o = '{dr: -2'sd1, dc:  2'sd1};
      STEP_W'(4): o = '{dr:  2'sd0, dc: -2'sd1};
      STEP_W'(5): o = '{dr:  2'sd0, dc:  2'sd1};
      STEP_W'(6): o = '{dr:  2'sd1, dc: -2'sd1};
      STEP_W'(7): o = '{dr:  2'sd1, dc:  2'sd0};
      STEP_W'(8): o = '{dr:  2'sd1, dc:  2'sd1};
      default:    o = '{dr:  2'sd0, dc:  2'sd0};
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lct_if.sv -----
// Valid/ready channel interfaces for toggle requests and toggle results.
`default_nettype none
interface lct_in_if import lct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIDE_W-1:0] row;
  logic [SIDE_W-1:0] column;
  modport source (output valid, output row, output column, input ready);
  modport sink   (input valid, input row, input column, output ready);
endinterface

interface lct_out_if import lct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             alive_now;
  logic [CNT_W-1:0] live_neighbours;
  logic             bad_coordinate;
  modport source (output valid, output alive_now, output live_neighbours,
                  output bad_coordinate, input ready);
  modport sink   (input valid, input alive_now, input live_neighbours,
                  input bad_coordinate, output ready);
endinterface
`default_nettype wire

// ----- hdl/lct_ctrl.sv -----
// Controller state machine that sequences clearing, toggles and result hand-off.
`default_nettype none
module lct_ctrl import lct_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire lct_status_t st,
  output lct_cmd_t         cmd
);

  lct_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (st.clear_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_nxt = st.bad ? ST_PUSH : ST_RUN;
      end
      ST_RUN:   if (st.run_last) state_nxt = ST_PUSH;
      ST_PUSH:  if (!st.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_RUN:   cmd.run = 1'b1;
      ST_PUSH:  cmd.load_out = !st.out_busy;
      default:  cmd = '0;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !st.out_busy)
    else $error("result loaded while the output register still holds a beat");

  a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> (state_r == ST_RUN) || (state_r == ST_PUSH))
    else $error("toggle sequence left without delivering a result");

endmodule
`default_nettype wire

// ----- hdl/lct_dpath.sv -----
// Datapath with the board memory, neighbor address generation and output register.
`default_nettype none
module lct_dpath import lct_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic [SIDE_W-1:0] in_row,
  input  wire logic [SIDE_W-1:0] in_column,
  input  wire lct_cmd_t          cmd,
  output lct_status_t            st,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_alive_now,
  output logic [CNT_W-1:0]       out_live_neighbours,
  output logic                   out_bad_coordinate
);

  lct_entry_t mem [CELLS];

  logic [CFG_W-1:0]  side_r, side_eff;
  logic [SIDE_W-1:0] row_r, col_r;
  logic              bad_r;
  logic [STEP_W-1:0] step_r;
  logic [ADDR_W-1:0] clr_r;
  lct_entry_t        rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              wr_en_r, wr_ctr_r, up_r;
  logic              ctr_alive_r;
  logic [CNT_W-1:0]  ctr_count_r;
  logic              out_valid_r;
  logic              out_alive_r, out_bad_r;
  logic [CNT_W-1:0]  out_count_r;

  lct_off_t          off;
  logic [COORD_W-1:0] nb_row, nb_col;
  logic              pos_valid, rd_en;
  lct_entry_t        wr_data;
  logic [CNT_W-1:0]  cnt_new;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  lct_entry_t        mem_wdata;

  always_comb begin
    side_eff = (side_r > SIDE_MAX) ? SIDE_MAX : side_r;
    st.bad   = ({1'b0, in_row} >= side_eff) || ({1'b0, in_column} >= side_eff);
    st.clear_last = cmd.clear && (clr_r == ADDR_W'(CELLS - 1));
    st.run_last   = (step_r == STEP_DONE);
    st.out_busy   = out_valid_r && !out_ready;
  end

  // Offsets are sign-extended so that a step past the low edge wraps to a large value.
  always_comb begin
    off       = nb_offset(step_r);
    nb_row    = {2'b00, row_r} + {{(COORD_W-2){off.dr[1]}}, off.dr};
    nb_col    = {2'b00, col_r} + {{(COORD_W-2){off.dc[1]}}, off.dc};
    pos_valid = (nb_row < {1'b0, side_eff}) && (nb_col < {1'b0, side_eff});
    rd_en     = cmd.run && (step_r <= STEP_LAST) && pos_valid;
    rd_addr   = {nb_row[SIDE_W-1:0], nb_col[SIDE_W-1:0]};
  end

  always_comb begin
    if (up_r) begin
      cnt_new = (rd_data_r.count < COUNT_MAX) ? rd_data_r.count + CNT_W'(1)
                                              : rd_data_r.count;
    end else begin
      cnt_new = (rd_data_r.count != '0) ? rd_data_r.count - CNT_W'(1)
                                        : rd_data_r.count;
    end
    if (wr_ctr_r) begin
      wr_data = '{alive: !rd_data_r.alive, count: rd_data_r.count};
    end else begin
      wr_data = '{alive: rd_data_r.alive, count: cnt_new};
    end
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en_r;
      mem_waddr = wr_addr_r;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= SIDE_RESET;
      clr_r       <= '0;
      step_r      <= '0;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) side_r <= cfg_wdata;
      if (cmd.clear) clr_r <= clr_r + ADDR_W'(1);
      if (cmd.accept) begin
        step_r <= '0;
      end else if (cmd.run) begin
        step_r <= step_r + STEP_W'(1);
      end
      wr_en_r <= rd_en;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_r <= in_row;
      col_r <= in_column;
      bad_r <= st.bad;
    end
    wr_addr_r <= rd_addr;
    wr_ctr_r  <= (step_r == STEP_CTR);
    if (wr_en_r && wr_ctr_r) begin
      up_r        <= !rd_data_r.alive;
      ctr_alive_r <= !rd_data_r.alive;
      ctr_count_r <= rd_data_r.count;
    end
    if (cmd.load_out) begin
      out_alive_r <= bad_r ? 1'b0 : ctr_alive_r;
      out_count_r <= bad_r ? '0 : ctr_count_r;
      out_bad_r   <= bad_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_alive_now       = out_alive_r;
  assign out_live_neighbours = out_count_r;
  assign out_bad_coordinate  = out_bad_r;

  a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en_r |-> $past(cmd.run))
    else $error("board write without a matching read in the previous cycle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |-> (step_r <= STEP_DONE))
    else $error("toggle step counter ran past the last neighbor");

endmodule
`default_nettype wire

// ----- hdl/life_cell_toggle_neighbour_count.sv -----
// Top level of the cell toggle block with incrementally kept neighbor counts.
//
// Each beat on in_ch names a cell by row and column of a square board of
// up to 64 by 64 cells. The block flips that cell and moves the stored
// live-neighbor count of each of its up to eight neighbors up or down by
// one, skipping neighbors past the edge. Each input beat gives one beat on
// out_ch with the new state, the cell's own count and a flag for a
// coordinate outside the board, in which case nothing changes.
// cfg_we with cfg_wdata writes the board side; write it only while idle.
// A valid toggle makes up to nine reads of the board memory (the cell and
// its eight neighbors, skipping any past the edge), one read per cycle with
// its write in the next cycle, plus hand-off. A bad coordinate skips the
// board and goes straight to hand-off.
// After reset all 4096 board memory entries are cleared, one entry a
// cycle, with in_ch.ready low; configuration writes are taken meanwhile.
// A new beat is accepted while a result still waits in the output register;
// if the receiver stalls, the next result waits until that register frees.
`default_nettype none
module life_cell_toggle_neighbour_count import lct_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  lct_in_if.sink                in_ch,
  lct_out_if.source             out_ch
);

  lct_cmd_t    cmd;
  lct_status_t st;

  lct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lct_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_row              (in_ch.row),
    .in_column           (in_ch.column),
    .cmd                 (cmd),
    .st                  (st),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_alive_now       (out_ch.alive_now),
    .out_live_neighbours (out_ch.live_neighbours),
    .out_bad_coordinate  (out_ch.bad_coordinate)
  );

endmodule
`default_nettype wire
